@@ design/sapq_pkg.sv @@
// Package for the sorted-array priority queue: operation kinds, status codes,
// controller states and the command/status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package sapq_pkg;

  // Operation carried in tuser of the input stream
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_STEP,
    S_INS_PUT,
    S_REM_RD,
    S_REM_TAKE,
    S_RESP
  } state_t;

  // Read address select for the store
  typedef enum logic [1:0] {
    RD_HEAD,
    RD_PREV,
    RD_PREV2
  } rd_sel_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic    accept;   // latch the input transaction, set up status
    rd_sel_t rd_sel;   // store read address
    logic    wr_val;   // write the new value at the cursor, count up
    logic    shift;    // move the read entry back one slot, cursor down
    logic    take;     // pop the head entry
  } dp_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic full;
    logic empty;
    logic last;        // cursor sits at one
    logic less;        // new value is below the entry just read
  } dp_stat_t;

endpackage : sapq_pkg

`default_nettype wire

@@ design/sapq_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module sapq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule : sapq_ram

`default_nettype wire

@@ design/sapq_dp.sv @@
// Datapath of the priority queue: ring head, count, insert cursor, result registers
// and the value store. Depends on sapq_pkg and sapq_ram.
`default_nettype none

module sapq_dp
  import sapq_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int SW    = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire dp_cmd_t     cmd,
  output dp_stat_t         stat,
  input  wire logic        in_kind,
  input  wire logic [31:0] in_value,
  output logic [1:0]       res_status,
  output logic [31:0]      res_removed,
  output logic [10:0]      res_occupancy
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // position in the ring, off entries behind the head
  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] head,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(head) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return AW'(sum);
  endfunction

  logic [AW-1:0] head_r,    head_nxt;
  logic [CW-1:0] count_r,   count_nxt;
  logic [CW-1:0] idx_r,     idx_nxt;
  logic [SW-1:0] val_r,     val_nxt;
  logic [SW-1:0] removed_r, removed_nxt;
  status_t       status_r,  status_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [SW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [SW-1:0] ram_rdata;
  logic          full;
  logic          empty;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  // status back to the controller
  always_comb begin
    stat.full  = full;
    stat.empty = empty;
    stat.last  = (idx_r == CW'(1));
    stat.less  = (val_r < ram_rdata);
  end

  // store read address
  always_comb begin
    case (cmd.rd_sel)
      RD_HEAD:  ram_raddr = head_r;
      RD_PREV:  ram_raddr = ring_pos(head_r, idx_r - CW'(1));
      RD_PREV2: ram_raddr = ring_pos(head_r, idx_r - CW'(2));
      default:  ram_raddr = head_r;
    endcase
  end

  // store write: new value or shifted entry, always at the cursor
  always_comb begin
    ram_we    = cmd.wr_val | cmd.shift;
    ram_waddr = ring_pos(head_r, idx_r);
    ram_wdata = cmd.shift ? ram_rdata : val_r;
  end

  // register updates
  always_comb begin
    head_nxt    = head_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    val_nxt     = val_r;
    removed_nxt = removed_r;
    status_nxt  = status_r;
    if (cmd.accept) begin
      val_nxt     = in_value[SW-1:0];
      idx_nxt     = count_r;
      removed_nxt = '0;
      status_nxt  = ST_OK;
      if (in_kind == KIND_INSERT && full) begin
        status_nxt = ST_FULL;
      end else if (in_kind == KIND_REMOVE && empty) begin
        status_nxt = ST_EMPTY;
      end
    end
    if (cmd.shift) begin
      idx_nxt = idx_r - CW'(1);
    end
    if (cmd.wr_val) begin
      count_nxt = count_r + CW'(1);
    end
    if (cmd.take) begin
      removed_nxt = ram_rdata;
      head_nxt    = ring_pos(head_r, CW'(1));
      count_nxt   = count_r - CW'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    val_r     <= val_nxt;
    removed_r <= removed_nxt;
    status_r  <= status_nxt;
  end

  sapq_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign res_status    = status_r;
  assign res_removed   = 32'(removed_r);
  assign res_occupancy = 11'(count_r);

endmodule : sapq_dp

`default_nettype wire

@@ design/sapq_ctrl.sv @@
// Controller state machine of the priority queue: input/output handshake and
// the insert/remove sequences. Depends on sapq_pkg.
`default_nettype none

module sapq_ctrl
  import sapq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_kind,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_INSERT) begin
            if (stat.full)       state_nxt = S_RESP;
            else if (stat.empty) state_nxt = S_INS_PUT;
            else                 state_nxt = S_INS_RD;
          end else begin
            if (stat.empty) state_nxt = S_RESP;
            else            state_nxt = S_REM_RD;
          end
        end
      end
      S_INS_RD:   state_nxt = S_INS_STEP;
      S_INS_STEP: begin
        if (stat.less)      state_nxt = S_RESP;
        else if (stat.last) state_nxt = S_INS_PUT;
      end
      S_INS_PUT:  state_nxt = S_RESP;
      S_REM_RD:   state_nxt = S_REM_TAKE;
      S_REM_TAKE: state_nxt = S_RESP;
      S_RESP: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd.accept = 1'b0;
    cmd.rd_sel = RD_HEAD;
    cmd.wr_val = 1'b0;
    cmd.shift  = 1'b0;
    cmd.take   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_INS_RD: cmd.rd_sel = RD_PREV;
      S_INS_STEP: begin
        // stop below a larger entry, else move this one back and read the next
        cmd.rd_sel = RD_PREV2;
        if (stat.less) cmd.wr_val = 1'b1;
        else           cmd.shift  = 1'b1;
      end
      S_INS_PUT:  cmd.wr_val = 1'b1;
      S_REM_RD:   cmd.rd_sel = RD_HEAD;
      S_REM_TAKE: cmd.take   = 1'b1;
      S_RESP:     out_valid  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule : sapq_ctrl

`default_nettype wire

@@ design/sorted_array_priority_queue_unit.sv @@
// Max-first priority queue held as a sorted ring in one simple dual-port RAM.
// Insert: every stored value not larger than the new one moves back one slot, one
// RAM read/write a cycle; an empty queue takes the value directly. Remove reads,
// then pops the head. Flagged items go straight to the result. One item is in flight at a time.
// Reset clears head and count at once; the store has no clearing pass.
// Depends on sapq_pkg, sapq_ctrl, sapq_dp, sapq_ram.
`default_nettype none

module sorted_array_priority_queue_unit
  import sapq_pkg::*;
#(
  parameter int DEPTH       = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  input  wire logic        in_tuser,   // [0] kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata   // [1:0] status, [33:2] removed_value,
                                       // [44:34] occupancy, [47:45] zero
);

  localparam int SW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [1:0]  res_status;
  logic [31:0] res_removed;
  logic [10:0] res_occupancy;

  sapq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_kind   (in_tuser),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sapq_dp #(
    .DEPTH (DEPTH),
    .SW    (SW)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_kind       (in_tuser),
    .in_value      (in_tdata),
    .res_status    (res_status),
    .res_removed   (res_removed),
    .res_occupancy (res_occupancy)
  );

  assign out_tdata = {3'b000, res_occupancy, res_removed, res_status};

endmodule : sorted_array_priority_queue_unit

`default_nettype wire
